// ===== hw/rtl/fme_pkg.sv =====
// fme_pkg: shared types, constants and constant tables for the fuzzy membership evaluator
package fme_pkg;

  localparam int DATA_WIDTH_DEF = 16;

  localparam logic [15:0] MEM_MAX = 16'hFFFF;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;

  // exponent argument limits: p < 2^28, so n = floor(p*256 / ln2) never exceeds 23
  localparam int P_W    = 28;
  localparam int N_MAX  = 23;
  localparam int N_W    = 5;
  localparam int AD_W   = 14;
  localparam int HORNER = 13;

  typedef enum logic [2:0] {
    SHAPE_GAUSS = 3'd0,
    SHAPE_TRI   = 3'd1,
    SHAPE_TRAP  = 3'd2,
    SHAPE_ASC   = 3'd3,
    SHAPE_DESC  = 3'd4
  } shape_t;

  typedef enum logic [2:0] {
    REG_SHAPE          = 3'd0,
    REG_CENTER         = 3'd1,
    REG_SPREAD         = 3'd2,
    REG_LEFT_FOOT      = 3'd3,
    REG_LEFT_SHOULDER  = 3'd4,
    REG_RIGHT_SHOULDER = 3'd5,
    REG_RIGHT_FOOT     = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_CONST     = 2'd0,
    KIND_RAMP      = 2'd1,
    KIND_GAUSS     = 2'd2,
    KIND_GAUSS_INV = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] cval;
    logic        st;
  } side_t;

  // ceil(2^(32+l)/j) with l = clog2(j): exact floor division of any 32-bit value by j
  localparam logic [32:0] RECIP [1:HORNER] = '{
    33'(((66'd1 << (32 + $clog2(1)))  + 66'd0)  / 66'd1),
    33'(((66'd1 << (32 + $clog2(2)))  + 66'd1)  / 66'd2),
    33'(((66'd1 << (32 + $clog2(3)))  + 66'd2)  / 66'd3),
    33'(((66'd1 << (32 + $clog2(4)))  + 66'd3)  / 66'd4),
    33'(((66'd1 << (32 + $clog2(5)))  + 66'd4)  / 66'd5),
    33'(((66'd1 << (32 + $clog2(6)))  + 66'd5)  / 66'd6),
    33'(((66'd1 << (32 + $clog2(7)))  + 66'd6)  / 66'd7),
    33'(((66'd1 << (32 + $clog2(8)))  + 66'd7)  / 66'd8),
    33'(((66'd1 << (32 + $clog2(9)))  + 66'd8)  / 66'd9),
    33'(((66'd1 << (32 + $clog2(10))) + 66'd9)  / 66'd10),
    33'(((66'd1 << (32 + $clog2(11))) + 66'd10) / 66'd11),
    33'(((66'd1 << (32 + $clog2(12))) + 66'd11) / 66'd12),
    33'(((66'd1 << (32 + $clog2(13))) + 66'd12) / 66'd13)
  };

  // smallest p with p*256 >= m*ln2
  function automatic logic [P_W-1:0] ln2_thr(input int m);
    logic [63:0] prod;
    prod = 64'(m) * 64'(LN2_Q32) + 64'd255;
    return P_W'(prod >> 8);
  endfunction

  function automatic logic [35:0] n_ln2(input logic [N_W-1:0] n);
    return 36'(n) * 36'(LN2_Q32);
  endfunction

endpackage

// ===== hw/rtl/fme_exp_step.sv =====
// fme_exp_step: one two-stage horner step of the exp(-r) series, e' = 1 - (r*e)/j
module fme_exp_step #(
  parameter int J = 1
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] r_in,
  input  logic [32:0] e_in,
  output logic [31:0] r_out,
  output logic [32:0] e_out
);
  import fme_pkg::*;

  localparam int SH = 32 + $clog2(J);

  logic [64:0] prod;
  logic [31:0] q;
  logic [31:0] r_mid;
  logic [65:0] qm;
  logic [31:0] quo;

  assign prod = 65'(r_in) * 65'(e_in);
  assign qm   = 66'(q) * 66'(RECIP[J]);
  assign quo  = 32'(qm >> SH);

  always_ff @(posedge clk) begin
    if (en) begin
      q     <= prod[63:32];
      r_mid <= r_in;
      r_out <= r_mid;
      e_out <= Q32_ONE - 33'(quo);
    end
  end

endmodule

// ===== hw/rtl/fme_div_bit.sv =====
// fme_div_bit: one restoring division stage, one quotient bit per register stage
module fme_div_bit #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] rem_in,
  input  logic [15:0]  lq_in,
  input  logic [W-1:0] den_in,
  output logic [W-1:0] rem_out,
  output logic [15:0]  lq_out,
  output logic [W-1:0] den_out
);
  import fme_pkg::*;

  logic [W:0] sh;
  logic       ge;

  // low dividend bits shift out of lq while quotient bits shift in
  assign sh = {rem_in, lq_in[15]};
  assign ge = sh >= {1'b0, den_in};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? W'(sh - {1'b0, den_in}) : W'(sh);
      lq_out  <= {lq_in[14:0], ge};
      den_out <= den_in;
    end
  end

endmodule

// ===== hw/rtl/fuzzy_membership_evaluator_unit.sv =====
// fuzzy_membership_evaluator_unit: pipelined fuzzy membership degree of one sample per beat
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  input   | in_valid/in_ready  | sample (signed Q8.8)
//  output  | out_valid/out_ready| membership (Q0.16), status (domain error)
//  config  | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
//  one beat per cycle sustained while out_ready is high or the output register is empty
//  the depth is set by the thirteen two-stage horner steps of the exp unit
//  the sixteen ramp division stages run alongside the exp steps
//  one pipeline enable: the whole pipe holds while the output register is full and unread
//  synchronous reset clears the valid bits and loads the configuration registers with defaults
module fuzzy_membership_evaluator_unit #(
  parameter int DATA_WIDTH = fme_pkg::DATA_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic signed [DATA_WIDTH-1:0]                  sample,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [15:0]                                   membership,
  output logic                                          status,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [2:0]                                    cfg_index,
  input  logic [((DATA_WIDTH > 16) ? DATA_WIDTH : 16)-1:0] cfg_data
);
  import fme_pkg::*;

  localparam int DW1  = DATA_WIDTH + 1;
  localparam int LAST = 33;

  // configuration registers
  logic [2:0]                   shape_mode;
  logic signed [DATA_WIDTH-1:0] center;
  logic [15:0]                  spread;
  logic signed [DATA_WIDTH-1:0] left_foot;
  logic signed [DATA_WIDTH-1:0] left_shoulder;
  logic signed [DATA_WIDTH-1:0] right_shoulder;
  logic signed [DATA_WIDTH-1:0] right_foot;

  // pipeline control
  logic             en;
  logic [LAST:0]    vld;

  // stage 0: sample capture
  logic signed [DATA_WIDTH-1:0] x0;

  // stage 1: shape decode
  side_t                 side_n;
  logic [DATA_WIDTH-1:0] num_n;
  logic [DATA_WIDTH-1:0] den_n;
  logic signed [DW1-1:0] dxa;
  logic [DW1-1:0]        ad;
  logic                  big;
  logic [AD_W-1:0]       ad14_1;
  logic                  gzpre1;
  logic [DATA_WIDTH-1:0] num1;
  logic [DATA_WIDTH-1:0] den1;
  side_t                 side [1:LAST-1];

  // gaussian front: square, scale, range reduce
  logic [P_W-1:0]        sq2;
  logic [43:0]           p_full;
  logic [P_W-1:0]        p3;
  logic [P_W-1:0]        p4;
  logic [N_W-1:0]        n_new;
  logic [N_W-1:0]        n_p [4:31];
  logic                  gz_p [2:31];
  logic [35:0]           t_red;
  logic [31:0]           r5;

  // exp series and back end
  logic [31:0]           r_h [0:HORNER];
  logic [32:0]           e_h [0:HORNER];
  logic [32:0]           v31;
  logic [47:0]           vm;
  logic [15:0]           g32;

  // ramp division
  logic [DATA_WIDTH+16:0] n_div;
  logic [DATA_WIDTH-1:0]  rem_d [0:16];
  logic [15:0]            lq_d  [0:16];
  logic [DATA_WIDTH-1:0]  den_d [0:16];
  logic [15:0]            quo_p [19:LAST-1];

  assign en        = !vld[LAST] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAST];
  assign cfg_ready = 1'b1;

  // configuration writes, indices beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode     <= SHAPE_GAUSS;
      center         <= '0;
      spread         <= 16'd256;
      left_foot      <= -DATA_WIDTH'(256);
      left_shoulder  <= '0;
      right_shoulder <= '0;
      right_foot     <= DATA_WIDTH'(256);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SHAPE:          shape_mode     <= cfg_data[2:0];
        REG_CENTER:         center         <= cfg_data[DATA_WIDTH-1:0];
        REG_SPREAD:         spread         <= cfg_data[15:0];
        REG_LEFT_FOOT:      left_foot      <= cfg_data[DATA_WIDTH-1:0];
        REG_LEFT_SHOULDER:  left_shoulder  <= cfg_data[DATA_WIDTH-1:0];
        REG_RIGHT_SHOULDER: right_shoulder <= cfg_data[DATA_WIDTH-1:0];
        REG_RIGHT_FOOT:     right_foot     <= cfg_data[DATA_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  // shape decode: the tests of each shape are tried in order and the first that holds wins
  always_comb begin
    side_n.kind = KIND_CONST;
    side_n.cval = '0;
    side_n.st   = 1'b0;
    num_n       = '0;
    den_n       = '0;
    case (shape_mode)
      SHAPE_GAUSS: begin
        side_n.kind = KIND_GAUSS;
      end
      SHAPE_TRI: begin
        if (x0 > center && x0 < right_foot) begin
          side_n.kind = KIND_RAMP;
          num_n = DATA_WIDTH'(DW1'(right_foot) - DW1'(x0));
          den_n = DATA_WIDTH'(DW1'(right_foot) - DW1'(center));
        end else if (x0 > left_foot && x0 < center) begin
          side_n.kind = KIND_RAMP;
          num_n = DATA_WIDTH'(DW1'(x0) - DW1'(left_foot));
          den_n = DATA_WIDTH'(DW1'(center) - DW1'(left_foot));
        end else if (x0 == left_foot || x0 == right_foot) begin
          side_n.cval = '0;
        end else if (x0 == center) begin
          side_n.cval = MEM_MAX;
        end
      end
      SHAPE_TRAP: begin
        if (x0 > right_shoulder && x0 < right_foot) begin
          side_n.kind = KIND_RAMP;
          num_n = DATA_WIDTH'(DW1'(right_foot) - DW1'(x0));
          den_n = DATA_WIDTH'(DW1'(right_foot) - DW1'(right_shoulder));
        end else if (x0 > left_foot && x0 < left_shoulder) begin
          side_n.kind = KIND_RAMP;
          num_n = DATA_WIDTH'(DW1'(x0) - DW1'(left_foot));
          den_n = DATA_WIDTH'(DW1'(left_shoulder) - DW1'(left_foot));
        end else if (x0 == left_foot || x0 == right_foot) begin
          side_n.cval = '0;
        end else if (x0 == center || x0 == left_shoulder || x0 == right_shoulder) begin
          side_n.cval = MEM_MAX;
        end else if (x0 > left_shoulder && x0 < right_shoulder) begin
          side_n.cval = MEM_MAX;
        end
      end
      SHAPE_ASC: begin
        if (x0 <= center && !x0[DATA_WIDTH-1]) begin
          side_n.cval = '0;
        end else if (x0 > center) begin
          side_n.kind = KIND_GAUSS_INV;
        end else begin
          side_n.st = 1'b1;
        end
      end
      SHAPE_DESC: begin
        if (x0 <= center && !x0[DATA_WIDTH-1]) begin
          side_n.cval = MEM_MAX;
        end else if (x0 > center) begin
          side_n.kind = KIND_GAUSS;
        end else begin
          side_n.st = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // distance from the centre; at or beyond 2^14 the exponent is past its cap whenever k is non-zero
  assign dxa = DW1'(x0) - DW1'(center);
  assign ad  = dxa[DW1-1] ? DW1'(-dxa) : DW1'(dxa);
  assign big = 34'(ad) >= 34'd16384;

  // gaussian: p = k*d*d, n = floor(p*256/ln2) by threshold compares, r = remainder
  assign p_full = 44'(spread) * 44'(sq2);

  always_comb begin
    n_new = '0;
    for (int m = 1; m <= N_MAX; m++) begin
      if (p3 >= ln2_thr(m)) begin
        n_new = N_W'(m);
      end
    end
  end

  assign t_red = {p4, 8'd0} - n_ln2(n_p[4]);

  // ramp dividend num*65535 + den/2, always below den*2^16
  assign n_div = ({1'b0, num1, 16'd0} - (DATA_WIDTH+17)'(num1)) + (DATA_WIDTH+17)'(den1 >> 1);

  // scale the series result by 2^-n; the shift and the rounding below both feed the g32 register
  assign v31 = e_h[HORNER] >> n_p[31];

  // 2^32 * v * 65535 / 2^32 rounded, v <= 2^32 keeps it below 2^48
  assign vm = ({v31[31:0], 16'd0} | 48'(v31[32]) << 48) - 48'(v31) + 48'h8000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      x0       <= sample;
      side[1]  <= side_n;
      ad14_1   <= AD_W'(ad);
      gzpre1   <= big && (spread != 16'd0);
      num1     <= num_n;
      den1     <= den_n;
      sq2      <= P_W'(ad14_1) * P_W'(ad14_1);
      gz_p[2]  <= gzpre1;
      p3       <= p_full[P_W-1:0];
      gz_p[3]  <= gz_p[2] || (p_full >= 44'h1000_0000);
      p4       <= p3;
      n_p[4]   <= n_new;
      r5       <= t_red[31:0];
      g32      <= gz_p[31] ? 16'd0 : vm[47:32];
      rem_d[0] <= n_div[DATA_WIDTH+15:16];
      lq_d[0]  <= n_div[15:0];
      den_d[0] <= den1;
      quo_p[19] <= lq_d[16];
      for (int i = 2; i <= LAST - 1; i++) side[i] <= side[i-1];
      for (int i = 4; i <= 31; i++) gz_p[i] <= gz_p[i-1];
      for (int i = 5; i <= 31; i++) n_p[i] <= n_p[i-1];
      for (int i = 20; i <= LAST - 1; i++) quo_p[i] <= quo_p[i-1];
      // output register
      status <= side[LAST-1].st;
      case (side[LAST-1].kind)
        KIND_CONST:     membership <= side[LAST-1].cval;
        KIND_RAMP:      membership <= quo_p[LAST-1];
        KIND_GAUSS:     membership <= g32;
        KIND_GAUSS_INV: membership <= MEM_MAX - g32;
        default:        membership <= '0;
      endcase
    end
  end

  // exp(-r) by horner steps j = 13 down to 1
  assign r_h[0] = r5;
  assign e_h[0] = Q32_ONE;

  for (genvar s = 0; s < HORNER; s++) begin : g_exp
    fme_exp_step #(
      .J(HORNER - s)
    ) u_step (
      .clk  (clk),
      .en   (en),
      .r_in (r_h[s]),
      .e_in (e_h[s]),
      .r_out(r_h[s+1]),
      .e_out(e_h[s+1])
    );
  end

  // ramp quotient, one bit per stage
  for (genvar d = 0; d < 16; d++) begin : g_div
    fme_div_bit #(
      .W(DATA_WIDTH)
    ) u_bit (
      .clk    (clk),
      .en     (en),
      .rem_in (rem_d[d]),
      .lq_in  (lq_d[d]),
      .den_in (den_d[d]),
      .rem_out(rem_d[d+1]),
      .lq_out (lq_d[d+1]),
      .den_out(den_d[d+1])
    );
  end

`ifndef ASSERT_OFF
  ap_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> membership == 16'd0)
    else $error("domain error beat carries a non-zero membership");

  ap_ramp_range: assert property (@(posedge clk) disable iff (rst)
    vld[18] && side[18].kind == KIND_RAMP |-> lq_d[16] != MEM_MAX)
    else $error("ramp quotient reached full scale");

  ap_exp_nonzero: assert property (@(posedge clk) disable iff (rst)
    vld[31] |-> e_h[HORNER] != 33'd0)
    else $error("exp series collapsed to zero");

  ap_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");
`endif

endmodule
